FILE: rtl/core/sst3_pkg.sv
package sst3_pkg;

    // translation table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int CODE_W      = 16;
    localparam int LED_W       = 3;

    // request and result kinds
    localparam logic REQ_SCAN        = 1'b0;
    localparam logic REQ_TABLE_WRITE = 1'b1;
    localparam logic KIND_KEY        = 1'b0;
    localparam logic KIND_LED        = 1'b1;

    // set 3 scan bytes with special handling
    localparam logic [7:0] BYTE_BREAK      = 8'hF0;
    localparam logic [7:0] KEY_SCROLL      = 8'h5F;
    localparam logic [7:0] KEY_NUM         = 8'h76;
    localparam logic [7:0] KEY_CAPS        = 8'h14;
    localparam logic [7:0] KEY_LSHIFT      = 8'h12;
    localparam logic [7:0] KEY_RSHIFT      = 8'h59;
    localparam logic [7:0] KEY_LCTRL       = 8'h11;
    localparam logic [7:0] KEY_RCTRL       = 8'h58;
    localparam logic [7:0] KEY_LWIN        = 8'h8B;
    localparam logic [7:0] KEY_RWIN        = 8'h8C;
    localparam logic [7:0] KEY_APPS        = 8'h8D;
    localparam logic [7:0] KEY_LALT        = 8'h19;
    localparam logic [7:0] KEY_RALT        = 8'h39;
    localparam logic [7:0] KEY_PRTSC       = 8'h57;
    localparam logic [7:0] KEY_KP_MINUS    = 8'h84;
    localparam logic [7:0] KP_MINUS_ENTRY  = 8'h4E;

    // keypad bytes remapped while num lock is off
    localparam logic [7:0] KP_1   = 8'h69;
    localparam logic [7:0] KP_2   = 8'h72;
    localparam logic [7:0] KP_3   = 8'h7A;
    localparam logic [7:0] KP_4   = 8'h6B;
    localparam logic [7:0] KP_5   = 8'h73;
    localparam logic [7:0] KP_6   = 8'h74;
    localparam logic [7:0] KP_7   = 8'h6C;
    localparam logic [7:0] KP_8   = 8'h75;
    localparam logic [7:0] KP_9   = 8'h7D;
    localparam logic [7:0] KP_0   = 8'h70;
    localparam logic [7:0] KP_DOT = 8'h71;

    // fixed output codes
    localparam logic [15:0] CODE_SHIFT_MAKE  = 16'h000F;
    localparam logic [15:0] CODE_SHIFT_BREAK = 16'h000E;
    localparam logic [15:0] CODE_PRTSC       = 16'h1000;
    localparam logic [15:0] CODE_SYSRQ       = 16'h1100;
    localparam logic [15:0] CODE_NAV_DEL     = 16'h1200;
    localparam logic [15:0] CODE_NAV_INS     = 16'h1300;
    localparam logic [15:0] CODE_NAV_HOME    = 16'h1400;
    localparam logic [15:0] CODE_NAV_END     = 16'h1500;
    localparam logic [15:0] CODE_NAV_PGUP    = 16'h1600;
    localparam logic [15:0] CODE_NAV_PGDN    = 16'h1700;
    localparam logic [15:0] CODE_NAV_LEFT    = 16'h1800;
    localparam logic [15:0] CODE_NAV_RIGHT   = 16'h1900;
    localparam logic [15:0] CODE_NAV_UP      = 16'h1A00;
    localparam logic [15:0] CODE_NAV_DOWN    = 16'h1B00;

    // caps lock range and modifier bits
    localparam logic [15:0] LOWER_A_MINUS1 = 16'h0060;
    localparam logic [15:0] LOWER_Z_PLUS1  = 16'h007B;
    localparam logic [15:0] CASE_OFFSET    = 16'h0020;
    localparam int          BIT_BREAK      = 13;
    localparam int          BIT_ALT        = 14;
    localparam int          BIT_CTRL       = 15;

    // lock flag bit positions
    localparam int LOCK_SCROLL = 0;
    localparam int LOCK_NUM    = 1;
    localparam int LOCK_CAPS   = 2;

    typedef struct packed {
        logic [LED_W-1:0] lock;
        logic             brk;
        logic             alt;
        logic             ctrl;
    } flags_t;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [CODE_W-1:0] key_code;
        logic [LED_W-1:0]  led_state;
    } dec_result_t;

endpackage

FILE: rtl/core/sst3_table.sv
module sst3_table (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [sst3_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [sst3_pkg::CODE_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [sst3_pkg::ADDR_W-1:0]  rd_addr,
    output logic [sst3_pkg::CODE_W-1:0]  rd_data
);
    import sst3_pkg::*;

    logic [CODE_W-1:0] mem [TABLE_DEPTH];
    logic [CODE_W-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/sst3_decode.sv
module sst3_decode (
    input  logic                        req_type,
    input  logic [7:0]                  scan_byte,
    input  logic [sst3_pkg::CODE_W-1:0] table_data,
    input  sst3_pkg::flags_t            flags,
    output sst3_pkg::dec_result_t       result,
    output sst3_pkg::flags_t            flags_next
);
    import sst3_pkg::*;

    logic              drop;
    logic              led_hit;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] nav_code;
    logic              nav_hit;
    logic              nav_drop;
    logic [CODE_W-1:0] final_code;

    // keypad remap while num lock is off
    always_comb begin
        nav_hit  = 1'b1;
        nav_drop = 1'b0;
        nav_code = '0;
        unique case (scan_byte)
            KP_DOT:  nav_code = CODE_NAV_DEL;
            KP_0:    nav_code = CODE_NAV_INS;
            KP_1:    nav_code = CODE_NAV_END;
            KP_2:    nav_code = CODE_NAV_DOWN;
            KP_3:    nav_code = CODE_NAV_PGDN;
            KP_4:    nav_code = CODE_NAV_LEFT;
            KP_5:    nav_drop = 1'b1;
            KP_6:    nav_code = CODE_NAV_RIGHT;
            KP_7:    nav_code = CODE_NAV_HOME;
            KP_8:    nav_code = CODE_NAV_UP;
            KP_9:    nav_code = CODE_NAV_PGUP;
            default: nav_hit = 1'b0;
        endcase
    end

    // byte decode and flag update
    always_comb begin
        flags_next = flags;
        drop       = 1'b0;
        led_hit    = 1'b0;
        code       = table_data;
        final_code = '0;
        result     = '0;

        if (req_type == REQ_TABLE_WRITE) begin
            drop = 1'b1;
        end else if (scan_byte == BYTE_BREAK) begin
            drop           = 1'b1;
            flags_next.brk = 1'b1;
        end else begin
            unique case (scan_byte) inside
                KEY_SCROLL, KEY_NUM, KEY_CAPS: begin
                    drop = 1'b1;
                    if (flags.brk) begin
                        led_hit = 1'b1;
                        if (scan_byte == KEY_SCROLL) begin
                            flags_next.lock[LOCK_SCROLL] = ~flags.lock[LOCK_SCROLL];
                        end else if (scan_byte == KEY_NUM) begin
                            flags_next.lock[LOCK_NUM] = ~flags.lock[LOCK_NUM];
                        end else begin
                            flags_next.lock[LOCK_CAPS] = ~flags.lock[LOCK_CAPS];
                        end
                    end
                end
                KEY_LSHIFT, KEY_RSHIFT: begin
                    code = flags.brk ? CODE_SHIFT_BREAK : CODE_SHIFT_MAKE;
                end
                KEY_LCTRL, KEY_RCTRL: begin
                    drop            = 1'b1;
                    flags_next.ctrl = ~flags.brk;
                end
                KEY_LWIN, KEY_RWIN, KEY_APPS: begin
                    drop = 1'b1;
                end
                KEY_LALT, KEY_RALT: begin
                    drop           = 1'b1;
                    flags_next.alt = ~flags.brk;
                end
                KEY_PRTSC: begin
                    code = flags.alt ? CODE_SYSRQ : CODE_PRTSC;
                end
                default: begin
                    code = table_data;
                end
            endcase

            // num lock off turns the keypad into navigation keys
            if (!drop && !flags.lock[LOCK_NUM] && nav_hit) begin
                code = nav_code;
                drop = nav_drop;
            end

            // caps lock uppercases a to z
            final_code = code;
            if (flags.lock[LOCK_CAPS] && code > LOWER_A_MINUS1 && code < LOWER_Z_PLUS1) begin
                final_code = code - CASE_OFFSET;
            end
            final_code[BIT_BREAK] = final_code[BIT_BREAK] | flags.brk;
            final_code[BIT_ALT]   = final_code[BIT_ALT] | flags.alt;
            final_code[BIT_CTRL]  = final_code[BIT_CTRL] | flags.ctrl;

            flags_next.brk = 1'b0;
        end

        // result assembly
        if (led_hit) begin
            result.valid     = 1'b1;
            result.kind      = KIND_LED;
            result.led_state = flags_next.lock;
        end else if (!drop) begin
            result.valid    = 1'b1;
            result.kind     = KIND_KEY;
            result.key_code = final_code;
        end
    end

endmodule

FILE: rtl/core/scancode_set3_translator.sv
// an accepted item is registered in the input stage, then in the result register
// throughput: one item per cycle while m_ready is high, table writes and scans alike
// the translation table is a 256 x 16 RAM with one write and one registered read port
// table contents are not cleared by reset; entries are valid only once written
// reset clears the lock, break, alt and control flags and both valid stages
module scancode_set3_translator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [7:0]                  s_scan_byte,
    input  logic [sst3_pkg::ADDR_W-1:0] s_table_index,
    input  logic [sst3_pkg::CODE_W-1:0] s_table_word,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_result_kind,
    output logic [sst3_pkg::CODE_W-1:0] m_key_code,
    output logic [sst3_pkg::LED_W-1:0]  m_led_state
);
    import sst3_pkg::*;

    logic              s_accept;
    logic              out_free;
    logic              s1_adv;
    logic              tbl_wr_en;
    logic              tbl_rd_en;
    logic [ADDR_W-1:0] tbl_rd_addr;
    logic [CODE_W-1:0] tbl_rd_data;

    logic              s1_valid_reg;
    logic              s1_req_reg;
    logic [7:0]        s1_byte_reg;
    flags_t            flags_reg;
    flags_t            flags_next;
    dec_result_t       dec_result;

    logic              m_valid_reg;
    logic              m_kind_reg;
    logic [CODE_W-1:0] m_key_code_reg;
    logic [LED_W-1:0]  m_led_reg;

    // handshake between input stage and result register
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        s1_adv   = s1_valid_reg && out_free;
        s_ready  = !s1_valid_reg || out_free;
        s_accept = s_valid && s_ready;
    end

    // table access happens at the accept edge
    always_comb begin
        tbl_wr_en   = s_accept && (s_req_type == REQ_TABLE_WRITE);
        tbl_rd_en   = s_accept && (s_req_type == REQ_SCAN);
        tbl_rd_addr = (s_scan_byte == KEY_KP_MINUS) ? KP_MINUS_ENTRY : s_scan_byte;
    end

    sst3_table u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (s_table_index),
        .wr_data (s_table_word),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    sst3_decode u_decode (
        .req_type   (s1_req_reg),
        .scan_byte  (s1_byte_reg),
        .table_data (tbl_rd_data),
        .flags      (flags_reg),
        .result     (dec_result),
        .flags_next (flags_next)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            flags_reg    <= '0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg && dec_result.valid;
            end
            if (s1_adv) begin
                flags_reg <= flags_next;
            end
        end
    end

    // input stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_req_reg  <= s_req_type;
            s1_byte_reg <= s_scan_byte;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (s1_adv && dec_result.valid) begin
            m_kind_reg     <= dec_result.kind;
            m_key_code_reg <= dec_result.key_code;
            m_led_reg      <= dec_result.led_state;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_key_code    = m_key_code_reg;
    assign m_led_state   = m_led_reg;

    // checks
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !s1_valid_reg))
        else $error("valid stages not cleared by reset");

    a_led_no_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_LED) |-> (m_key_code_reg == '0))
        else $error("led update carries a key code");

    a_key_no_led: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_KEY) |-> (m_led_reg == '0))
        else $error("key code carries led state");

    a_lock_change_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (flags_reg.lock != $past(flags_reg.lock)) |->
            (m_valid_reg && m_kind_reg == KIND_LED && m_led_reg == flags_reg.lock))
        else $error("lock flags changed without led update");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled while result register empty");

endmodule

FILE: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sst3_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 50;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] code;
        logic [LED_W-1:0]  led;
    } key_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_req_type    = REQ_SCAN;
    logic [7:0]          s_scan_byte   = '0;
    logic [ADDR_W-1:0]   s_table_index = '0;
    logic [CODE_W-1:0]   s_table_word  = '0;
    logic                m_ready       = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic                m_result_kind;
    logic [CODE_W-1:0]   m_key_code;
    logic [LED_W-1:0]    m_led_state;

    // predictor state
    logic [CODE_W-1:0]   key_table [TABLE_DEPTH];
    logic [LED_W-1:0]    lock_state  = '0;
    logic                break_seen  = 1'b0;
    logic                alt_down    = 1'b0;
    logic                ctrl_down   = 1'b0;
    key_result_t         expected_results [$];
    key_result_t         oldest_result;

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    scancode_set3_translator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_scan_byte   (s_scan_byte),
        .s_table_index (s_table_index),
        .s_table_word  (s_table_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_key_code    (m_key_code),
        .m_led_state   (m_led_state)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // expected key code or led update for one accepted item
    task automatic predict_key(input logic rt, input logic [7:0] sb,
                               input logic [ADDR_W-1:0] ti, input logic [CODE_W-1:0] tw);
        logic [CODE_W-1:0] code;
        logic              emit;
        key_result_t       res;
        if (rt == REQ_TABLE_WRITE) begin
            key_table[ti] = tw;
            return;
        end
        if (sb == BYTE_BREAK) begin
            break_seen = 1'b1;
            return;
        end
        code = '0;
        emit = 1'b1;
        case (sb)
            KEY_SCROLL, KEY_NUM, KEY_CAPS: begin
                emit = 1'b0;
                // only a release toggles the lock
                if (break_seen) begin
                    if (sb == KEY_SCROLL)
                        lock_state[LOCK_SCROLL] = ~lock_state[LOCK_SCROLL];
                    else if (sb == KEY_NUM)
                        lock_state[LOCK_NUM] = ~lock_state[LOCK_NUM];
                    else
                        lock_state[LOCK_CAPS] = ~lock_state[LOCK_CAPS];
                    res.kind = KIND_LED;
                    res.code = '0;
                    res.led  = lock_state;
                    expected_results.push_back(res);
                end
            end
            KEY_LSHIFT, KEY_RSHIFT: code = break_seen ? CODE_SHIFT_BREAK : CODE_SHIFT_MAKE;
            KEY_LCTRL, KEY_RCTRL: begin
                ctrl_down = ~break_seen;
                emit = 1'b0;
            end
            KEY_LWIN, KEY_RWIN, KEY_APPS: emit = 1'b0;
            KEY_LALT, KEY_RALT: begin
                alt_down = ~break_seen;
                emit = 1'b0;
            end
            KEY_PRTSC: code = alt_down ? CODE_SYSRQ : CODE_PRTSC;
            KEY_KP_MINUS: code = key_table[KP_MINUS_ENTRY];
            default: code = key_table[sb];
        endcase
        // keypad navigation while num lock is off
        if (emit && !lock_state[LOCK_NUM]) begin
            case (sb)
                KP_DOT: code = CODE_NAV_DEL;
                KP_0:   code = CODE_NAV_INS;
                KP_1:   code = CODE_NAV_END;
                KP_2:   code = CODE_NAV_DOWN;
                KP_3:   code = CODE_NAV_PGDN;
                KP_4:   code = CODE_NAV_LEFT;
                KP_5:   emit = 1'b0;
                KP_6:   code = CODE_NAV_RIGHT;
                KP_7:   code = CODE_NAV_HOME;
                KP_8:   code = CODE_NAV_UP;
                KP_9:   code = CODE_NAV_PGUP;
                default: ;
            endcase
        end
        if (emit) begin
            if (lock_state[LOCK_CAPS] && code > LOWER_A_MINUS1 && code < LOWER_Z_PLUS1)
                code = code - CASE_OFFSET;
            code[BIT_BREAK] = code[BIT_BREAK] | break_seen;
            code[BIT_ALT]   = code[BIT_ALT] | alt_down;
            code[BIT_CTRL]  = code[BIT_CTRL] | ctrl_down;
            res.kind = KIND_KEY;
            res.code = code;
            res.led  = '0;
            expected_results.push_back(res);
        end
        break_seen = 1'b0;
    endtask

    // offer one item, wait for it to be taken, then predict its result
    task automatic send_item(input logic rt, input logic [7:0] sb,
                             input logic [ADDR_W-1:0] ti, input logic [CODE_W-1:0] tw);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= rt;
        s_scan_byte   <= sb;
        s_table_index <= ti;
        s_table_word  <= tw;
        do @(posedge aclk); while (!s_ready);
        predict_key(rt, sb, ti, tw);
    endtask

    task automatic send_scan(input logic [7:0] sb);
        send_item(REQ_SCAN, sb, ADDR_W'($urandom_range(255)), CODE_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic send_write(input logic [ADDR_W-1:0] ti, input logic [CODE_W-1:0] tw);
        send_item(REQ_TABLE_WRITE, 8'($urandom_range(255)), ti, tw);
    endtask

    // a third of the words land in the lowercase letter range
    function automatic logic [CODE_W-1:0] pick_table_word();
        if ($urandom_range(2) == 0)
            return CODE_W'($urandom_range(16'h61, 16'h7A));
        return CODE_W'($urandom_range(16'hFFFF));
    endfunction

    // fill every entry, with the letter boundaries placed at known bytes
    task automatic test_table_load();
        logic [CODE_W-1:0] word;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (i)
                8'h00:   word = 16'h0000;
                8'hFF:   word = 16'hFFFF;
                8'h1C:   word = 16'h0061;
                8'h32:   word = 16'h007A;
                8'h21:   word = LOWER_A_MINUS1;
                8'h23:   word = LOWER_Z_PLUS1;
                default: word = pick_table_word();
            endcase
            send_write(ADDR_W'(i), word);
        end
    endtask

    // shift, print screen, modifiers, swallowed keys, keypad minus
    task automatic test_special_keys();
        send_scan(KEY_LSHIFT);
        send_scan(BYTE_BREAK);
        send_scan(KEY_RSHIFT);
        send_scan(KEY_PRTSC);
        send_scan(KEY_LALT);
        send_scan(KEY_PRTSC);
        send_scan(BYTE_BREAK);
        send_scan(KEY_RALT);
        send_scan(KEY_RCTRL);
        send_scan(8'h00);
        send_scan(BYTE_BREAK);
        send_scan(KEY_LCTRL);
        send_scan(KEY_LWIN);
        send_scan(KEY_RWIN);
        send_scan(KEY_APPS);
        send_scan(KEY_KP_MINUS);
        send_scan(BYTE_BREAK);
        send_scan(8'hFF);
    endtask

    // lock toggles, caps range edges, keypad with num lock off and on
    task automatic test_lock_keys();
        send_scan(KEY_CAPS);
        send_scan(BYTE_BREAK);
        send_scan(KEY_CAPS);
        send_scan(8'h1C);
        send_scan(8'h32);
        send_scan(8'h21);
        send_scan(8'h23);
        send_scan(KP_5);
        send_scan(KP_1);
        send_scan(BYTE_BREAK);
        send_scan(KEY_NUM);
        send_scan(KP_5);
        send_scan(BYTE_BREAK);
        send_scan(KEY_SCROLL);
    endtask

    // mostly keystrokes with optional release prefix, plus writes and noise
    task automatic run_random(input int strokes);
        logic [7:0] key;
        int         r;
        for (int n = 0; n < strokes; n++) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_write(ADDR_W'($urandom_range(255)), pick_table_word());
            end else if (r < 20) begin
                send_scan(8'($urandom_range(255)));
            end else begin
                if ($urandom_range(99) < 40)
                    send_scan(BYTE_BREAK);
                case ($urandom_range(24))
                    0:  key = KEY_SCROLL;
                    1:  key = KEY_NUM;
                    2:  key = KEY_CAPS;
                    3:  key = KEY_LSHIFT;
                    4:  key = KEY_RSHIFT;
                    5:  key = KEY_LCTRL;
                    6:  key = KEY_RCTRL;
                    7:  key = KEY_LWIN;
                    8:  key = KEY_RWIN;
                    9:  key = KEY_APPS;
                    10: key = KEY_LALT;
                    11: key = KEY_RALT;
                    12: key = KEY_PRTSC;
                    13: key = KEY_KP_MINUS;
                    14: key = KP_0;
                    15: key = KP_1;
                    16: key = KP_2;
                    17: key = KP_3;
                    18: key = KP_4;
                    19: key = KP_5;
                    20: key = KP_6;
                    21: key = KP_7;
                    22: key = KP_8;
                    default: key = ($urandom_range(1) == 0) ? KP_9 : KP_DOT;
                endcase
                // half the keystrokes hit a table key instead
                if ($urandom_range(1) == 0)
                    key = 8'($urandom_range(255));
                send_scan(key);
            end
        end
    endtask

    // receiver holds off while shift items keep coming, so the input stalls
    task automatic test_backpressure();
        hold_requests++;
        repeat (40) send_scan(KEY_LSHIFT);
    endtask

    // receiver ready, with random stalls and the long hold
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each result with the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d code %h led %h",
                         $time, m_result_kind, m_key_code, m_led_state);
                error_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_result_kind !== oldest_result.kind) begin
                    $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                             $time, oldest_result.kind, m_result_kind);
                    error_count++;
                end
                if (m_key_code !== oldest_result.code) begin
                    $display("%0t: key_code mismatch, expected %h, actual %h",
                             $time, oldest_result.code, m_key_code);
                    error_count++;
                end
                if (m_led_state !== oldest_result.led) begin
                    $display("%0t: led_state mismatch, expected %h, actual %h",
                             $time, oldest_result.led, m_led_state);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        send_idle_pct  = 11;
        recv_stall_pct = 62;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_table_load();
        test_special_keys();
        test_lock_keys();
        run_random(80);
        send_idle_pct  = 62;
        recv_stall_pct = 11;
        run_random(80);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        run_random(80);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
